// File: rtl/mono_page_framebuffer_draw_top_defines.svh
// Assertion macros for the monochrome page framebuffer drawing engine
`ifndef MONO_PAGE_FRAMEBUFFER_DRAW_TOP_DEFINES_SVH
`define MONO_PAGE_FRAMEBUFFER_DRAW_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define MPFD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MPFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/mpfd_pkg.sv
// Types and constants shared by the framebuffer drawing engine
package mpfd_pkg;

	localparam logic [2:0] ACT_SET_PIXEL = 3'd0;
	localparam logic [2:0] ACT_INV_PIXEL = 3'd1;
	localparam logic [2:0] ACT_FILL_RECT = 3'd2;
	localparam logic [2:0] ACT_INV_RECT  = 3'd3;
	localparam logic [2:0] ACT_OUTLINE   = 3'd4;
	localparam logic [2:0] ACT_FILL_ALL  = 3'd5;
	localparam logic [2:0] ACT_CLEAR_ALL = 3'd6;
	localparam logic [2:0] ACT_READ      = 3'd7;

	localparam logic [1:0] PH_LEFT   = 2'd0;
	localparam logic [1:0] PH_RIGHT  = 2'd1;
	localparam logic [1:0] PH_TOP    = 2'd2;
	localparam logic [1:0] PH_BOTTOM = 2'd3;

	localparam logic [7:0] BYTE_ONES  = 8'hFF;
	localparam logic [7:0] BYTE_ZEROS = 8'h00;

	// wide enough for any page * column + column with 8-bit coordinates
	localparam int LOC_W = 14;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] row;
		logic [7:0] col;
		logic [7:0] width;
		logic [7:0] height;
		logic       color;
	} cmd_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       clipped;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_RUN,
		ST_WRITE,
		ST_READ,
		ST_RESP
	} state_t;

endpackage

// File: rtl/mpfd_locate.sv
// Pixel address unit: clipping test and byte address of one pixel
module mpfd_locate #(
	parameter int COLUMNS     = 101,
	parameter int PAGES       = 5,
	parameter int LAST_ROW    = 32,
	parameter int LAST_COLUMN = 100,
	parameter int AW          = 9
) (
	input  logic [7:0]    row,
	input  logic [7:0]    col,
	output logic [AW-1:0] addr,
	output logic          on
);

	localparam int MEM_BYTES = PAGES * COLUMNS;

	logic [mpfd_pkg::LOC_W-1:0] full;

	always_comb begin
		full = mpfd_pkg::LOC_W'(row[7:3]) * mpfd_pkg::LOC_W'(COLUMNS)
			+ mpfd_pkg::LOC_W'(col);
		on = (row <= 8'(LAST_ROW)) && (col <= 8'(LAST_COLUMN))
			&& (full < mpfd_pkg::LOC_W'(MEM_BYTES));
		addr = full[AW-1:0];
	end

endmodule

// File: rtl/mpfd_mem.sv
// Display memory, one write and one registered read port
module mpfd_mem #(
	parameter int DEPTH = 505,
	parameter int AW    = 9
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/mono_page_framebuffer_draw_top.sv
// Top level of the monochrome page framebuffer drawing engine
// After reset a fill pass writes 0xFF over all PAGES*COLUMNS bytes, one per cycle; no beat is
// taken meanwhile. Fill all and clear all sweep every byte, then load the result. Pixel and read
// actions read the byte, then write it back or capture it; rectangles and outlines do so for each
// visible pixel of each run and skip clipped ones, through one shared address unit and one
// read-modify-write memory port. The next beat can be taken the cycle after the result loads.
`include "mono_page_framebuffer_draw_top_defines.svh"

module mono_page_framebuffer_draw_top #(
	parameter int COLUMNS     = 101,
	parameter int PAGES       = 5,
	parameter int LAST_ROW    = 32,
	parameter int LAST_COLUMN = 100
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_stall,
	input  mpfd_pkg::cmd_t  cmd,
	output logic            res_valid,
	input  logic            res_stall,
	output mpfd_pkg::res_t  res
);

	localparam int MEM_BYTES = PAGES * COLUMNS;
	localparam int AW        = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;

	mpfd_pkg::state_t state_q, state_d;

	logic [2:0]    act_q;
	logic [7:0]    row_q, col_q, w_q, h_q;
	logic          color_q;
	logic [7:0]    i_q, k_q;
	logic [1:0]    phase_q;
	logic          clip_q;
	logic [7:0]    rd_q;
	logic [AW-1:0] addr_q;
	logic [2:0]    bit_q;
	logic [AW-1:0] sweep_addr_q;
	logic          fill_q;
	logic          sweep_rsp_q;
	logic          res_valid_q;
	mpfd_pkg::res_t res_q;

	logic       is_rect, is_outline, is_single, is_flip, dir_row;
	logic [7:0] run_n, rb, cb, pr, pc;
	logic       in_run, more_runs, sweep_last, accept, res_load;
	logic [AW-1:0] loc_addr;
	logic       loc_on;
	logic       mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0] mem_wdata, mem_rdata, mask, pix_byte;

	// run generator: which run, its base pixel, direction and length
	always_comb begin
		is_rect    = (act_q == mpfd_pkg::ACT_FILL_RECT) || (act_q == mpfd_pkg::ACT_INV_RECT);
		is_outline = (act_q == mpfd_pkg::ACT_OUTLINE);
		is_single  = !is_rect && !is_outline;
		is_flip    = (act_q == mpfd_pkg::ACT_INV_PIXEL) || (act_q == mpfd_pkg::ACT_INV_RECT);
		dir_row    = is_outline
			&& ((phase_q == mpfd_pkg::PH_TOP) || (phase_q == mpfd_pkg::PH_BOTTOM));
		rb = row_q;
		cb = col_q;
		run_n = 8'd1;
		if (is_rect) begin
			rb = row_q + i_q;
			run_n = (w_q == 8'd0) ? 8'd0 : h_q;
		end else if (is_outline) begin
			unique case (phase_q)
				mpfd_pkg::PH_LEFT: run_n = h_q;
				mpfd_pkg::PH_RIGHT: begin
					rb = row_q + w_q;
					run_n = h_q;
				end
				mpfd_pkg::PH_TOP: run_n = w_q;
				mpfd_pkg::PH_BOTTOM: begin
					cb = col_q + h_q;
					run_n = w_q + 8'd1;
				end
				default: run_n = h_q;
			endcase
		end
		pr = dir_row ? rb + k_q : rb;
		pc = dir_row ? cb : cb + k_q;
		in_run = k_q < run_n;
		more_runs = is_rect ? ((9'(i_q) + 9'd1) < 9'(w_q))
			: (is_outline && (phase_q != mpfd_pkg::PH_BOTTOM));
		sweep_last = sweep_addr_q == AW'(MEM_BYTES - 1);
		accept = cmd_valid && !cmd_stall;
		res_load = (state_q == mpfd_pkg::ST_RESP) && (!res_valid_q || !res_stall);
	end

	mpfd_locate #(
		.COLUMNS    (COLUMNS),
		.PAGES      (PAGES),
		.LAST_ROW   (LAST_ROW),
		.LAST_COLUMN(LAST_COLUMN),
		.AW         (AW)
	) u_locate (
		.row (pr),
		.col (pc),
		.addr(loc_addr),
		.on  (loc_on)
	);

	mpfd_mem #(
		.DEPTH(MEM_BYTES),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(loc_addr),
		.rdata(mem_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mpfd_pkg::ST_IDLE: begin
				if (accept) begin
					if ((cmd.action == mpfd_pkg::ACT_FILL_ALL)
						|| (cmd.action == mpfd_pkg::ACT_CLEAR_ALL)) begin
						state_d = mpfd_pkg::ST_SWEEP;
					end else begin
						state_d = mpfd_pkg::ST_RUN;
					end
				end
			end
			mpfd_pkg::ST_SWEEP: begin
				if (sweep_last) begin
					state_d = sweep_rsp_q ? mpfd_pkg::ST_RESP : mpfd_pkg::ST_IDLE;
				end
			end
			mpfd_pkg::ST_RUN: begin
				if (in_run) begin
					if (loc_on) begin
						state_d = (act_q == mpfd_pkg::ACT_READ) ? mpfd_pkg::ST_READ
							: mpfd_pkg::ST_WRITE;
					end
				end else if (!more_runs) begin
					state_d = mpfd_pkg::ST_RESP;
				end
			end
			mpfd_pkg::ST_WRITE: state_d = mpfd_pkg::ST_RUN;
			mpfd_pkg::ST_READ:  state_d = mpfd_pkg::ST_RESP;
			mpfd_pkg::ST_RESP: begin
				if (res_load) begin
					state_d = mpfd_pkg::ST_IDLE;
				end
			end
			default: state_d = mpfd_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		mask = 8'd1 << bit_q;
		if (is_flip) begin
			pix_byte = mem_rdata ^ mask;
		end else if (color_q) begin
			pix_byte = mem_rdata | mask;
		end else begin
			pix_byte = mem_rdata & ~mask;
		end
		cmd_stall = state_q != mpfd_pkg::ST_IDLE;
		mem_we = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = pix_byte;
		unique case (state_q)
			mpfd_pkg::ST_SWEEP: begin
				mem_we = 1'b1;
				mem_waddr = sweep_addr_q;
				mem_wdata = fill_q ? mpfd_pkg::BYTE_ONES : mpfd_pkg::BYTE_ZEROS;
			end
			mpfd_pkg::ST_WRITE: mem_we = 1'b1;
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mpfd_pkg::ST_SWEEP;
			sweep_addr_q <= '0;
			fill_q <= 1'b1;
			sweep_rsp_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				sweep_addr_q <= '0;
				fill_q <= cmd.action == mpfd_pkg::ACT_FILL_ALL;
				sweep_rsp_q <= 1'b1;
			end else if (state_q == mpfd_pkg::ST_SWEEP) begin
				sweep_addr_q <= sweep_addr_q + AW'(1);
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= cmd.action;
			row_q <= cmd.row;
			col_q <= cmd.col;
			w_q <= cmd.width;
			h_q <= cmd.height;
			color_q <= cmd.color;
			i_q <= '0;
			k_q <= '0;
			phase_q <= mpfd_pkg::PH_LEFT;
			clip_q <= 1'b0;
			rd_q <= '0;
		end
		unique case (state_q)
			mpfd_pkg::ST_RUN: begin
				if (in_run) begin
					addr_q <= loc_addr;
					bit_q <= pr[2:0];
					if (!loc_on) begin
						k_q <= k_q + 8'd1;
						if (is_single) begin
							clip_q <= 1'b1;
						end
					end
				end else begin
					k_q <= '0;
					i_q <= i_q + 8'd1;
					phase_q <= phase_q + 2'd1;
				end
			end
			mpfd_pkg::ST_WRITE: k_q <= k_q + 8'd1;
			mpfd_pkg::ST_READ:  rd_q <= mem_rdata;
			default: ;
		endcase
		if (res_load) begin
			res_q.read_data <= rd_q;
			res_q.clipped <= clip_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

	`MPFD_ASSERT_NOW(a_we_src, mem_we, (state_q == mpfd_pkg::ST_SWEEP) || (state_q == mpfd_pkg::ST_WRITE), "memory written outside sweep or pixel write")
	`MPFD_ASSERT_NEXT(a_write_after_run, state_q == mpfd_pkg::ST_RUN && state_d == mpfd_pkg::ST_WRITE, state_q == mpfd_pkg::ST_WRITE && $past(loc_on), "pixel write without a visible pixel")
	`MPFD_ASSERT_NEXT(a_res_load, res_load, res_valid && state_q == mpfd_pkg::ST_IDLE, "result not presented after completion")
	`MPFD_ASSERT_NOW(a_clip_zero, res_valid && res.clipped, res.read_data == mpfd_pkg::BYTE_ZEROS, "clipped result carries read data")

endmodule

// File: test/testbench.sv
// Testbench for mono_page_framebuffer_draw_top: drawing commands against a shadow frame
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COLS       = 101;
	localparam int PAGE_COUNT = 5;
	localparam int LAST_R     = 32;
	localparam int LAST_C     = 100;
	localparam int FRAME_SIZE = COLS * PAGE_COUNT;
	localparam int RANDOM_CMDS = 1325;
	localparam int DRAIN_CYCLES = 100;

	typedef enum int {
		STALL_NONE,
		STALL_HALF,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	mpfd_pkg::cmd_t cmd = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	mpfd_pkg::res_t res;

	logic [7:0] shadow_frame [FRAME_SIZE];
	mpfd_pkg::res_t awaited_replies [$];
	int burst_left = 0;
	int errors = 0;
	int compared = 0;
	int action_count [8];
	stall_mode_t stall_mode = STALL_NONE;
	int stall_left = 0;

	mono_page_framebuffer_draw_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#50ms;
		$display("FAIL mono_page_framebuffer_draw_top");
		$finish;
	end

	// shadow frame: byte address of a pixel, and whether it lies on display
	function automatic bit pixel_addr(logic [7:0] r, logic [7:0] c, output int addr);
		addr = int'(r >> 3) * COLS + int'(c);
		return (int'(r) <= LAST_R) && (int'(c) <= LAST_C) && (addr < FRAME_SIZE);
	endfunction

	function automatic bit plot(logic [7:0] r, logic [7:0] c, logic color);
		int addr;
		if (!pixel_addr(r, c, addr))
			return 1'b0;
		shadow_frame[addr][r[2:0]] = color;
		return 1'b1;
	endfunction

	function automatic bit toggle(logic [7:0] r, logic [7:0] c);
		int addr;
		if (!pixel_addr(r, c, addr))
			return 1'b0;
		shadow_frame[addr][r[2:0]] = ~shadow_frame[addr][r[2:0]];
		return 1'b1;
	endfunction

	function automatic void row_line(logic [7:0] r, logic [7:0] c, logic [7:0] n, logic color);
		for (int i = 0; i < int'(n); i++)
			void'(plot(r + 8'(i), c, color));
	endfunction

	function automatic void col_line(logic [7:0] r, logic [7:0] c, logic [7:0] n, logic color);
		for (int j = 0; j < int'(n); j++)
			void'(plot(r, c + 8'(j), color));
	endfunction

	// applies one command to the shadow frame and returns the reply it should give
	function automatic mpfd_pkg::res_t apply_drawing(mpfd_pkg::cmd_t c);
		mpfd_pkg::res_t rep;
		int addr;
		rep = '0;
		case (c.action)
			mpfd_pkg::ACT_SET_PIXEL: rep.clipped = !plot(c.row, c.col, c.color);
			mpfd_pkg::ACT_INV_PIXEL: rep.clipped = !toggle(c.row, c.col);
			mpfd_pkg::ACT_FILL_RECT, mpfd_pkg::ACT_INV_RECT: begin
				for (int i = 0; i < int'(c.width); i++)
					for (int j = 0; j < int'(c.height); j++)
						if (c.action == mpfd_pkg::ACT_FILL_RECT)
							void'(plot(c.row + 8'(i), c.col + 8'(j), c.color));
						else
							void'(toggle(c.row + 8'(i), c.col + 8'(j)));
			end
			mpfd_pkg::ACT_OUTLINE: begin
				col_line(c.row, c.col, c.height, c.color);
				col_line(c.row + c.width, c.col, c.height, c.color);
				row_line(c.row, c.col, c.width, c.color);
				row_line(c.row, c.col + c.height, c.width + 8'd1, c.color);
			end
			mpfd_pkg::ACT_FILL_ALL:
				foreach (shadow_frame[k]) shadow_frame[k] = mpfd_pkg::BYTE_ONES;
			mpfd_pkg::ACT_CLEAR_ALL:
				foreach (shadow_frame[k]) shadow_frame[k] = mpfd_pkg::BYTE_ZEROS;
			default: begin
				if (pixel_addr(c.row, c.col, addr))
					rep.read_data = shadow_frame[addr];
				else
					rep.clipped = 1'b1;
			end
		endcase
		return rep;
	endfunction

	function automatic mpfd_pkg::cmd_t make_cmd(logic [2:0] action, logic [7:0] r,
			logic [7:0] c, logic [7:0] w, logic [7:0] h, logic color);
		mpfd_pkg::cmd_t m;
		m.action = action;
		m.row    = r;
		m.col    = c;
		m.width  = w;
		m.height = h;
		m.color  = color;
		return m;
	endfunction

	// called at a rising edge; returns at the edge that took the beat
	task automatic send_cmd(mpfd_pkg::cmd_t c);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		cmd <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
		awaited_replies.push_back(apply_drawing(c));
		action_count[c.action]++;
	endtask

	task automatic read_byte(logic [7:0] r, logic [7:0] c);
		send_cmd(make_cmd(mpfd_pkg::ACT_READ, r, c, 8'd0, 8'd0, 1'b0));
	endtask

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_left = $urandom_range(8, 80);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			STALL_NONE:     res_stall <= 1'b0;
			STALL_HALF:     res_stall <= 1'($urandom_range(0, 1));
			STALL_HEAVY:    res_stall <= ($urandom_range(0, 7) != 0);
			STALL_PERIODIC: res_stall <= (stall_left % 4 == 0);
		endcase
	end

	always @(posedge clk) begin
		mpfd_pkg::res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (awaited_replies.size() == 0) begin
				$error("reply beat with nothing outstanding: read_data %h clipped %b",
					res.read_data, res.clipped);
				errors++;
			end else begin
				want = awaited_replies.pop_front();
				compared++;
				if (res.read_data !== want.read_data) begin
					$error("read_data: expected %h, got %h", want.read_data, res.read_data);
					errors++;
				end
				if (res.clipped !== want.clipped) begin
					$error("clipped: expected %b, got %b", want.clipped, res.clipped);
					errors++;
				end
			end
		end
	end

	task automatic test_power_up_contents();
		read_byte(8'd0, 8'd0);
		read_byte(8'd32, 8'd100);
		read_byte(8'd33, 8'd0);
		read_byte(8'd0, 8'd101);
		read_byte(8'd255, 8'd255);
	endtask

	task automatic test_single_pixels();
		send_cmd(make_cmd(mpfd_pkg::ACT_SET_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
		send_cmd(make_cmd(mpfd_pkg::ACT_INV_PIXEL, 8'd32, 8'd100, 8'd0, 8'd0, 1'b0));
		read_byte(8'd32, 8'd100);
		send_cmd(make_cmd(mpfd_pkg::ACT_SET_PIXEL, 8'd40, 8'd5, 8'd0, 8'd0, 1'b1));
		send_cmd(make_cmd(mpfd_pkg::ACT_INV_PIXEL, 8'd5, 8'd200, 8'd0, 8'd0, 1'b1));
	endtask

	task automatic test_whole_frame();
		send_cmd(make_cmd(mpfd_pkg::ACT_CLEAR_ALL, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
		read_byte(8'd9, 8'd9);
		send_cmd(make_cmd(mpfd_pkg::ACT_SET_PIXEL, 8'd17, 8'd60, 8'd0, 8'd0, 1'b1));
		read_byte(8'd16, 8'd60);
		send_cmd(make_cmd(mpfd_pkg::ACT_FILL_ALL, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
		send_cmd(make_cmd(mpfd_pkg::ACT_CLEAR_ALL, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
	endtask

	task automatic test_rectangles();
		// partly off display, then zero extents, then wrap past 255
		send_cmd(make_cmd(mpfd_pkg::ACT_FILL_RECT, 8'd30, 8'd95, 8'd10, 8'd10, 1'b1));
		read_byte(8'd32, 8'd100);
		send_cmd(make_cmd(mpfd_pkg::ACT_FILL_RECT, 8'd0, 8'd0, 8'd0, 8'd50, 1'b1));
		send_cmd(make_cmd(mpfd_pkg::ACT_FILL_RECT, 8'd0, 8'd0, 8'd20, 8'd0, 1'b1));
		send_cmd(make_cmd(mpfd_pkg::ACT_INV_RECT, 8'd250, 8'd250, 8'd20, 8'd10, 1'b0));
		read_byte(8'd8, 8'd3);
		send_cmd(make_cmd(mpfd_pkg::ACT_INV_RECT, 8'd0, 8'd0, 8'd255, 8'd255, 1'b0));
	endtask

	task automatic test_outlines();
		send_cmd(make_cmd(mpfd_pkg::ACT_OUTLINE, 8'd3, 8'd4, 8'd20, 8'd30, 1'b0));
		read_byte(8'd23, 8'd34);
		send_cmd(make_cmd(mpfd_pkg::ACT_OUTLINE, 8'd0, 8'd0, 8'd255, 8'd255, 1'b1));
		send_cmd(make_cmd(mpfd_pkg::ACT_OUTLINE, 8'd12, 8'd50, 8'd0, 8'd0, 1'b0));
		read_byte(8'd12, 8'd50);
	endtask

	task automatic test_random_drawing();
		mpfd_pkg::cmd_t c;
		int pick;
		for (int n = 0; n < RANDOM_CMDS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 20)      c.action = mpfd_pkg::ACT_SET_PIXEL;
			else if (pick < 32) c.action = mpfd_pkg::ACT_INV_PIXEL;
			else if (pick < 44) c.action = mpfd_pkg::ACT_FILL_RECT;
			else if (pick < 54) c.action = mpfd_pkg::ACT_INV_RECT;
			else if (pick < 62) c.action = mpfd_pkg::ACT_OUTLINE;
			else if (pick < 64) c.action = mpfd_pkg::ACT_FILL_ALL;
			else if (pick < 66) c.action = mpfd_pkg::ACT_CLEAR_ALL;
			else                c.action = mpfd_pkg::ACT_READ;
			if ($urandom_range(0, 99) < 85) begin
				c.row = 8'($urandom_range(0, 35));
				c.col = 8'($urandom_range(0, 103));
			end else begin
				c.row = 8'($urandom_range(0, 255));
				c.col = 8'($urandom_range(0, 255));
			end
			if ((c.action == mpfd_pkg::ACT_OUTLINE && $urandom_range(0, 3) == 0) ||
					((c.action == mpfd_pkg::ACT_FILL_RECT || c.action == mpfd_pkg::ACT_INV_RECT) &&
					$urandom_range(0, 199) < 3)) begin
				c.width  = 8'($urandom_range(0, 255));
				c.height = 8'($urandom_range(0, 255));
			end else begin
				c.width  = 8'($urandom_range(0, 10));
				c.height = 8'($urandom_range(0, 24));
			end
			c.color = 1'($urandom_range(0, 1));
			send_cmd(c);
		end
	endtask

	initial begin
		foreach (shadow_frame[k]) shadow_frame[k] = mpfd_pkg::BYTE_ONES;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_power_up_contents();
		test_single_pixels();
		test_whole_frame();
		test_rectangles();
		test_outlines();
		test_random_drawing();

		cmd_valid <= 1'b0;
		while (awaited_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Drew %0d set / %0d invert pixels, %0d fill / %0d invert rects, %0d outlines,",
			action_count[mpfd_pkg::ACT_SET_PIXEL], action_count[mpfd_pkg::ACT_INV_PIXEL],
			action_count[mpfd_pkg::ACT_FILL_RECT], action_count[mpfd_pkg::ACT_INV_RECT],
			action_count[mpfd_pkg::ACT_OUTLINE]);
		$display("%0d fill-all, %0d clears, %0d byte reads; %0d replies compared, %0d errors.",
			action_count[mpfd_pkg::ACT_FILL_ALL], action_count[mpfd_pkg::ACT_CLEAR_ALL],
			action_count[mpfd_pkg::ACT_READ], compared, errors);
		if (errors == 0)
			$display("PASS mono_page_framebuffer_draw_top");
		else
			$display("FAIL mono_page_framebuffer_draw_top");
		$finish;
	end

endmodule

// File: mono_page_framebuffer_draw_top.f
+incdir+rtl
rtl/mpfd_pkg.sv
rtl/mpfd_locate.sv
rtl/mpfd_mem.sv
rtl/mono_page_framebuffer_draw_top.sv
test/testbench.sv
